>>> hdl/rbs_pkg.sv
// Shared types and constants for the record bubble sorter.
// Used by rbs_mem, rbs_cswap and record_bubble_sort_by_key.
package rbs_pkg;

  localparam int RECORDS = 16;
  localparam int IDX_W   = $clog2(RECORDS);
  localparam int CNT_W   = $clog2(RECORDS + 1);
  localparam int KEY_W   = 16;
  localparam int PAY_W   = 32;
  localparam int DATA_W  = KEY_W + PAY_W;

  typedef struct packed {
    logic [PAY_W-1:0] payload;
    logic [KEY_W-1:0] key;
  } rec_t;

  // Compare-exchange result: smaller record goes back to the store,
  // larger one travels on through the pass.
  typedef struct packed {
    rec_t lo;
    rec_t hi;
  } pair_t;

  // Write request into the record store.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    rec_t             rec;
  } wr_req_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PSTART,
    ST_PFIRST,
    ST_PSTEP,
    ST_PEND,
    ST_EMIT,
    ST_ELOAD
  } state_e;

endpackage

>>> hdl/rbs_mem.sv
// Record store: one write port, one read port with registered read data.
// Depends on rbs_pkg.
module rbs_mem
  import rbs_pkg::*;
(
  input  logic             clk_i,
  input  wr_req_t          wr_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output rec_t             rd_data_o
);

  rec_t mem [RECORDS];
  rec_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.rec;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/rbs_cswap.sv
// Compare-exchange unit shared by every step of every sort pass.
// Depends on rbs_pkg. Swaps only on strictly greater key (stable).
module rbs_cswap
  import rbs_pkg::*;
(
  input  rec_t  carry_i,
  input  rec_t  next_i,
  output pair_t pair_o
);

  logic swap;

  assign swap      = carry_i.key > next_i.key;
  assign pair_o.lo = swap ? next_i : carry_i;
  assign pair_o.hi = swap ? carry_i : next_i;

endmodule

>>> hdl/record_bubble_sort_by_key.sv
// Top level of the record sorter: load, bubble-sort sequencer, emit.
// Depends on rbs_pkg, rbs_mem and rbs_cswap.
//
//  group  | dir | tdata (low bit up)          | tlast       | tuser
//  s_*    | in  | key[15:0], payload[47:16]   | final_item  | -
//  m_*    | out | sorted_key, sorted_payload  | end_of_run  | overflow
//
// Loading accepts one beat per cycle. For a set of n records the sort makes
// n-1 passes, each reading the store through the single read port and
// comparing in the shared compare-exchange unit. Emitting reads each record
// in ST_EMIT and registers it in ST_ELOAD, waiting while a held beat is not taken.
// s_tready_o is high only while loading. No clearing pass after reset.
module record_bubble_sort_by_key
  import rbs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [DATA_W-1:0] s_tdata_i,   // key, payload
  input  logic              s_tlast_i,   // final_item
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [DATA_W-1:0] m_tdata_o,   // sorted_key, sorted_payload
  output logic              m_tlast_o,   // end_of_run
  output logic              m_tuser_o    // overflow
);

  state_e           st_q, st_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0] end_q, end_d;
  rec_t             carry_q, carry_d;
  logic             ovalid_q, ovalid_d;
  rec_t             orec_q, orec_d;
  logic             olast_q, olast_d;
  logic             oovf_q, oovf_d;

  wr_req_t          wr;
  logic [IDX_W-1:0] rd_addr;
  rec_t             rd_data;
  pair_t            pair;
  rec_t             in_rec;
  logic             s_beat;
  logic             room;
  logic [CNT_W-1:0] n_next;
  logic             out_free;
  logic             emit_last;

  rbs_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  rbs_cswap u_cswap (
    .carry_i (carry_q),
    .next_i  (rd_data),
    .pair_o  (pair)
  );

  assign in_rec.key     = s_tdata_i[KEY_W-1:0];
  assign in_rec.payload = s_tdata_i[DATA_W-1:KEY_W];
  assign s_tready_o     = (st_q == ST_LOAD);
  assign s_beat         = s_tvalid_i && s_tready_o;
  assign room           = cnt_q < CNT_W'(RECORDS);
  assign n_next         = room ? cnt_q + CNT_W'(1) : cnt_q;
  assign out_free       = !ovalid_q || m_tready_i;
  assign emit_last      = (CNT_W'(pos_q) + CNT_W'(1)) == cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_LOAD;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    end_q   <= end_d;
    carry_q <= carry_d;
    orec_q  <= orec_d;
    olast_q <= olast_d;
    oovf_q  <= oovf_d;
  end

  always_comb begin
    st_d     = st_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    pos_d    = pos_q;
    end_d    = end_q;
    carry_d  = carry_q;
    ovalid_d = ovalid_q && !m_tready_i;
    orec_d   = orec_q;
    olast_d  = olast_q;
    oovf_d   = oovf_q;
    wr.en    = 1'b0;
    wr.addr  = pos_q;
    wr.rec   = pair.lo;
    rd_addr  = '0;

    case (st_q)
      ST_LOAD: begin
        if (s_beat) begin
          if (room) begin
            wr.en   = 1'b1;
            wr.addr = cnt_q[IDX_W-1:0];
            wr.rec  = in_rec;
            cnt_d   = n_next;
          end else begin
            ovf_d = 1'b1;
          end
          if (s_tlast_i) begin
            end_d = IDX_W'(n_next - CNT_W'(1));
            pos_d = '0;
            st_d  = (n_next == CNT_W'(1)) ? ST_EMIT : ST_PSTART;
          end
        end
      end
      ST_PSTART: begin
        rd_addr = '0;
        st_d    = ST_PFIRST;
      end
      ST_PFIRST: begin
        carry_d = rd_data;
        rd_addr = IDX_W'(1);
        pos_d   = '0;
        st_d    = ST_PSTEP;
      end
      ST_PSTEP: begin
        // store the smaller at pos, carry the larger to the next compare
        wr.en   = 1'b1;
        wr.addr = pos_q;
        wr.rec  = pair.lo;
        carry_d = pair.hi;
        if (pos_q + IDX_W'(1) == end_q) begin
          st_d = ST_PEND;
        end else begin
          rd_addr = pos_q + IDX_W'(2);
          pos_d   = pos_q + IDX_W'(1);
        end
      end
      ST_PEND: begin
        wr.en   = 1'b1;
        wr.addr = end_q;
        wr.rec  = carry_q;
        pos_d   = '0;
        if (end_q == IDX_W'(1)) begin
          st_d = ST_EMIT;
        end else begin
          end_d = end_q - IDX_W'(1);
          st_d  = ST_PFIRST;
        end
      end
      ST_EMIT: begin
        rd_addr = pos_q;
        if (out_free) begin
          st_d = ST_ELOAD;
        end
      end
      ST_ELOAD: begin
        ovalid_d = 1'b1;
        orec_d   = rd_data;
        olast_d  = emit_last;
        oovf_d   = ovf_q;
        if (emit_last) begin
          cnt_d = '0;
          ovf_d = 1'b0;
          st_d  = ST_LOAD;
        end else begin
          pos_d = pos_q + IDX_W'(1);
          st_d  = ST_EMIT;
        end
      end
      default: begin
        st_d = ST_LOAD;
      end
    endcase
  end

  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o  = {orec_q.payload, orec_q.key};
  assign m_tlast_o  = olast_q;
  assign m_tuser_o  = oovf_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(RECORDS))
    else $error("record count beyond capacity");

  a_pass_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_PSTEP) |-> (pos_q < end_q) && (CNT_W'(end_q) < cnt_q))
    else $error("sort step outside stored records");

  a_final_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_beat && s_tlast_i) |=> !s_tready_o)
    else $error("input still taken after final beat");

  a_out_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_ELOAD) |-> (!m_tvalid_o || m_tready_i))
    else $error("output register overwritten while holding a beat");
`endif

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for record_bubble_sort_by_key: directed, back-pressure and random record sets,
// checked against a stable bubble-sort predictor. Depends on rbs_pkg and the sorter RTL.
module tb_top;
  import rbs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef enum int unsigned {
    RX_FREE,
    RX_COIN,
    RX_SLOW
  } rx_mode_e;

  typedef struct packed {
    rec_t rec;
    logic run_end;
    logic ovf;
  } sorted_beat_t;

  logic              clk;
  logic              rst_n;
  logic              s_tvalid;
  logic              s_tready;
  rec_t              s_tdata;   // key, payload
  logic              s_tlast;   // final_item
  logic              m_tvalid;
  logic              m_tready;
  logic [DATA_W-1:0] m_tdata;   // sorted_key, sorted_payload
  logic              m_tlast;   // end_of_run
  logic              m_tuser;   // overflow

  rec_t         open_set[$];
  logic         set_overflow = 1'b0;
  sorted_beat_t sorted_q[$];
  int unsigned  errors     = 0;
  int unsigned  cycles     = 0;
  int unsigned  burst_left = 0;
  int unsigned  rx_hold    = 0;
  int unsigned  rx_left    = 0;
  rx_mode_e     rx_mode    = RX_FREE;

  record_bubble_sort_by_key uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tlast_i  (s_tlast),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tlast_o  (m_tlast),
    .m_tuser_o  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stores the record (or drops it when full); a final item sorts the set and
  // queues one expected beat per stored record.
  function automatic void absorb_record(rec_t rec, logic last);
    sorted_beat_t beat;
    rec_t         tmp;
    int           n;
    if (open_set.size() < RECORDS) open_set.push_back(rec);
    else set_overflow = 1'b1;
    if (last) begin
      n = open_set.size();
      for (int p = 0; p + 1 < n; p++) begin
        for (int i = 0; i + 1 < n - p; i++) begin
          // strict compare keeps equal keys in arrival order
          if (open_set[i].key > open_set[i+1].key) begin
            tmp           = open_set[i];
            open_set[i]   = open_set[i+1];
            open_set[i+1] = tmp;
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        beat.rec     = open_set[i];
        beat.run_end = (i == n - 1);
        beat.ovf     = set_overflow;
        sorted_q.push_back(beat);
      end
      open_set.delete();
      set_overflow = 1'b0;
    end
  endfunction

  // Called at a falling edge with tvalid as the previous beat left it; returns at a
  // falling edge after the beat is accepted.
  task automatic send_record(input logic [KEY_W-1:0] key, input logic [PAY_W-1:0] payload,
                             input logic last);
    int unsigned gap;
    rec_t        rec;
    rec.key     = key;
    rec.payload = payload;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rec;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    absorb_record(rec, last);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (sorted_q.size() != 0);
    burst_left = 0;
  endtask

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = $urandom_range(10, 80);
      end
      rx_left--;
      if (rx_hold != 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE: m_tready <= 1'b1;
          RX_COIN: m_tready <= ($urandom_range(0, 1) == 1);
          default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    sorted_beat_t want;
    rec_t         got;
    if (rst_n && m_tvalid && m_tready) begin
      got = rec_t'(m_tdata);
      if (sorted_q.size() == 0) begin
        $error("unexpected beat: key %h payload %h", got.key, got.payload);
        errors++;
      end else begin
        want = sorted_q.pop_front();
        if (got.key !== want.rec.key) begin
          $error("sorted_key: expected %h, got %h", want.rec.key, got.key);
          errors++;
        end
        if (got.payload !== want.rec.payload) begin
          $error("sorted_payload: expected %h, got %h", want.rec.payload, got.payload);
          errors++;
        end
        if (m_tlast !== want.run_end) begin
          $error("end_of_run: expected %b, got %b", want.run_end, m_tlast);
          errors++;
        end
        if (m_tuser !== want.ovf) begin
          $error("overflow: expected %b, got %b", want.ovf, m_tuser);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    // lone record, then a reversed pair at the field extremes
    send_record(16'h1234, 32'hCAFE_0001, 1'b1);
    send_record(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_record(16'h0000, 32'h0000_0000, 1'b1);
    // equal keys must keep arrival order
    send_record(16'h0040, 32'h0000_00A1, 1'b0);
    send_record(16'h0010, 32'h0000_00B0, 1'b0);
    send_record(16'h0040, 32'h0000_00A2, 1'b0);
    send_record(16'h0040, 32'h0000_00A3, 1'b1);
    // full store in descending order, one extra beat and the final beat dropped
    for (int i = 0; i < RECORDS + 2; i++)
      send_record(16'hFFFF - 16'(i) * 16'h0101, 32'h8000_0000 | 32'(i), i == RECORDS + 1);
    wait_drained();
  endtask

  // Output held off long enough that the second set stalls at the input.
  task automatic test_backpressure();
    rx_hold = HOLD_CYCLES;
    for (int s = 0; s < 2; s++)
      for (int i = 0; i < 8; i++)
        send_record(16'($urandom()), $urandom(), i == 7);
    wait_drained();
  endtask

  task automatic test_random_sets(input int unsigned items);
    int unsigned      sent;
    int unsigned      size;
    logic             narrow;
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] key;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 7))
        0:       size = $urandom_range(RECORDS, RECORDS + 4);
        1:       size = $urandom_range(1, RECORDS);
        default: size = $urandom_range(1, 8);
      endcase
      // narrow key ranges give plenty of duplicate keys
      narrow = ($urandom_range(0, 2) == 0);
      base   = 16'($urandom());
      for (int i = 0; i < size; i++) begin
        key = narrow ? base + 16'($urandom_range(0, 3)) : 16'($urandom());
        send_record(key, $urandom(), i == size - 1);
      end
      sent += size;
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    s_tvalid = 1'b0;
    s_tlast  = 1'b0;
    s_tdata  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random_sets(80);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
